### sv/bfpa_pkg.sv
// Shared types, constants and codes of the best-fit pool allocator.
// No dependencies; every other file of the block imports this package.
package bfpa_pkg;

  // Field widths of the channels and the configuration port
  localparam int ADDR_W     = 48;
  localparam int CMD_W      = 2;
  localparam int REQ_W      = 26;
  localparam int BYTES_W    = 26;
  localparam int NP_W       = 5;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 48;

  // Pool geometry (ALIGN_BYTES must be a power of two)
  localparam int PAGE_BYTES   = 2097152;
  localparam int ALIGN_BYTES  = 512;
  localparam int MAX_PAGES    = 16;
  localparam int FREE_ENTRIES = 64;
  localparam int USED_ENTRIES = 64;
  localparam int POOL_RESET   = 16;

  localparam int PAGE_LOG2 = $clog2(PAGE_BYTES);
  localparam int PG_W      = $clog2(MAX_PAGES);
  // offsets and lengths inside the pool, including the full pool size
  localparam int OFF_W     = $clog2(MAX_PAGES * PAGE_BYTES) + 1;
  localparam int SIZE_W    = REQ_W + 1;
  localparam int POS_W     = OFF_W + 1;
  localparam int COV_W     = OFF_W + 4;

  typedef enum logic [CMD_W-1:0] {
    CMD_ALLOC = 2'd0,
    CMD_FREE  = 2'd1,
    CMD_EMPTY = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EXHAUSTED = 2'd1,
    ST_UNKNOWN   = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    ACT_NONE  = 2'd0,
    ACT_MAP   = 2'd1,
    ACT_UNMAP = 2'd2
  } action_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_POOL_PAGES   = 1'b0,
    CFG_BASE_ADDRESS = 1'b1
  } cfg_reg_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_A_SCAN,
    S_A_WR_FREE,
    S_A_WR_USED,
    S_A_MAP,
    S_F_USCAN,
    S_F_FSCAN,
    S_F_WR1,
    S_F_WR2,
    S_E_SCAN,
    S_E_QUAL,
    S_EMIT,
    S_RESP
  } state_t;

  // Registered read result of a block table
  typedef struct packed {
    logic             en;
    logic             valid;
    logic [OFF_W-1:0] start;
    logic [OFF_W-1:0] len;
  } tbl_rd_t;

  // Write request to a block table
  typedef struct packed {
    logic             en;
    logic             valid;
    logic [OFF_W-1:0] start;
    logic [OFF_W-1:0] len;
  } tbl_wr_t;

endpackage

### sv/bfpa_if.sv
// Valid/ready channel interfaces for the command and result streams.
// Depends on bfpa_pkg for field widths.
interface bfpa_in_if import bfpa_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  command;
  logic [REQ_W-1:0]  request_size;
  logic [ADDR_W-1:0] block_address;

  modport source (output valid, command, request_size, block_address, input ready);
  modport sink   (input valid, command, request_size, block_address, output ready);
endinterface

interface bfpa_out_if import bfpa_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic [ADDR_W-1:0]  result_address;
  logic [PG_W-1:0]    page_index;
  logic [1:0]         page_action;
  logic [BYTES_W-1:0] allocated_bytes;
  logic [BYTES_W-1:0] mapped_bytes;
  logic               last;

  modport source (output valid, status, result_address, page_index, page_action,
                  allocated_bytes, mapped_bytes, last, input ready);
  modport sink   (input valid, status, result_address, page_index, page_action,
                  allocated_bytes, mapped_bytes, last, output ready);
endinterface

### sv/best_fit_pool_allocator.sv
// Best-fit pool allocator with coalescing: pool configuration registers,
// free and used block tables, and the command sequencer.
// Depends on bfpa_pkg, bfpa_if, bfpa_table and bfpa_ctrl.
//
// Usage: one command transaction at a time enters on in_ch (allocate, free,
// empty cache). Each command produces one or more result transactions on
// out_ch; the final one has last set. Allocate reports one result per newly
// mapped page, empty cache one per unmapped page, otherwise a single result.
// Every table walk reads one entry per cycle; allocate walks both tables
// together up to the larger table size. in_ch.ready is high only in idle,
// so the next command can be accepted in the cycle after the last result
// is loaded. Results leave through an output register; each receiver stall
// cycle delays the block. Reset clears all table valid bits, the high-water
// mark, the page map and the byte counters at once; no clearing pass is
// needed. The configuration registers take writes at any cycle and are
// meant to change only while idle.
module best_fit_pool_allocator import bfpa_pkg::*; #(
  parameter int N_FREE = FREE_ENTRIES,
  parameter int N_USED = USED_ENTRIES
) (
  input  logic                  clk,
  input  logic                  rst_n,
  bfpa_in_if.sink               in_ch,
  bfpa_out_if.source            out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int F_IDX_W = $clog2(N_FREE);
  localparam int U_IDX_W = $clog2(N_USED);

  logic [NP_W-1:0]   pool_pages_r;
  logic [ADDR_W-1:0] base_r;
  logic [NP_W-1:0]   pool_np;

  logic               f_rd_en, u_rd_en;
  logic [F_IDX_W-1:0] f_rd_idx, f_wr_idx;
  logic [U_IDX_W-1:0] u_rd_idx, u_wr_idx;
  tbl_rd_t            f_rd, u_rd;
  tbl_wr_t            f_wr, u_wr;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pool_pages_r <= NP_W'(POOL_RESET);
      base_r       <= '0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_POOL_PAGES:   pool_pages_r <= cfg_data[NP_W-1:0];
        CFG_BASE_ADDRESS: base_r       <= cfg_data[ADDR_W-1:0];
        default: ;
      endcase
    end
  end

  // Pool size clamped to 1..MAX_PAGES
  always_comb begin
    if (pool_pages_r == '0) pool_np = NP_W'(1);
    else if (pool_pages_r > NP_W'(MAX_PAGES)) pool_np = NP_W'(MAX_PAGES);
    else pool_np = pool_pages_r;
  end

  bfpa_table #(.ENTRIES(N_FREE)) u_free_tbl (
    .clk    (clk),
    .rst_n  (rst_n),
    .rd_en  (f_rd_en),
    .rd_idx (f_rd_idx),
    .rd     (f_rd),
    .wr     (f_wr),
    .wr_idx (f_wr_idx)
  );

  bfpa_table #(.ENTRIES(N_USED)) u_used_tbl (
    .clk    (clk),
    .rst_n  (rst_n),
    .rd_en  (u_rd_en),
    .rd_idx (u_rd_idx),
    .rd     (u_rd),
    .wr     (u_wr),
    .wr_idx (u_wr_idx)
  );

  bfpa_ctrl #(.N_FREE(N_FREE), .N_USED(N_USED)) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_ch        (in_ch),
    .out_ch       (out_ch),
    .pool_np      (pool_np),
    .base_address (base_r),
    .f_rd_en      (f_rd_en),
    .f_rd_idx     (f_rd_idx),
    .f_rd         (f_rd),
    .f_wr         (f_wr),
    .f_wr_idx     (f_wr_idx),
    .u_rd_en      (u_rd_en),
    .u_rd_idx     (u_rd_idx),
    .u_rd         (u_rd),
    .u_wr         (u_wr),
    .u_wr_idx     (u_wr_idx)
  );

endmodule

### sv/bfpa_table.sv
// Block table: start/length memory with one read and one write port,
// registered read data, and per-entry valid flops. Depends on bfpa_pkg.
module bfpa_table import bfpa_pkg::*; #(
  parameter int  ENTRIES = FREE_ENTRIES,
  localparam int IDX_W   = $clog2(ENTRIES)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             rd_en,
  input  logic [IDX_W-1:0] rd_idx,
  output tbl_rd_t          rd,
  input  tbl_wr_t          wr,
  input  logic [IDX_W-1:0] wr_idx
);

  logic [2*OFF_W-1:0] mem [ENTRIES];
  logic [ENTRIES-1:0] valid_r;
  logic [2*OFF_W-1:0] rd_data_r;
  logic               rd_en_r;
  logic               rd_valid_r;

  // Memory array: one write, one registered read
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr_idx] <= {wr.start, wr.len};
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_idx];
    end
  end

  // Valid flops and read qualifiers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      rd_en_r    <= 1'b0;
      rd_valid_r <= 1'b0;
    end else begin
      if (wr.en) begin
        valid_r[wr_idx] <= wr.valid;
      end
      rd_en_r    <= rd_en;
      rd_valid_r <= rd_en & valid_r[rd_idx];
    end
  end

  assign rd.en    = rd_en_r;
  assign rd.valid = rd_valid_r;
  assign rd.start = rd_data_r[2*OFF_W-1:OFF_W];
  assign rd.len   = rd_data_r[OFF_W-1:0];

endmodule

### sv/bfpa_ctrl.sv
// Command sequencer: scans the free and used tables, decides, writes back,
// tracks pages and counters, and drives the registered result stage.
// Depends on bfpa_pkg and the channel interfaces in bfpa_if.sv.
module bfpa_ctrl import bfpa_pkg::*; #(
  parameter int  N_FREE  = FREE_ENTRIES,
  parameter int  N_USED  = USED_ENTRIES,
  localparam int F_IDX_W = $clog2(N_FREE),
  localparam int U_IDX_W = $clog2(N_USED)
) (
  input  logic               clk,
  input  logic               rst_n,
  bfpa_in_if.sink            in_ch,
  bfpa_out_if.source         out_ch,
  input  logic [NP_W-1:0]    pool_np,
  input  logic [ADDR_W-1:0]  base_address,
  output logic               f_rd_en,
  output logic [F_IDX_W-1:0] f_rd_idx,
  input  tbl_rd_t            f_rd,
  output tbl_wr_t            f_wr,
  output logic [F_IDX_W-1:0] f_wr_idx,
  output logic               u_rd_en,
  output logic [U_IDX_W-1:0] u_rd_idx,
  input  tbl_rd_t            u_rd,
  output tbl_wr_t            u_wr,
  output logic [U_IDX_W-1:0] u_wr_idx
);

  localparam int SCAN_N = (N_FREE > N_USED) ? N_FREE : N_USED;
  localparam int SCAN_W = $clog2(SCAN_N + 1);

  // Control registers
  state_t                 state_r, state_nxt;
  logic [SCAN_W-1:0]      scan_idx_r, scan_idx_nxt;
  logic [SCAN_W-1:0]      cmp_idx_r;
  logic                   cmp_vld_r, cmp_vld_nxt;
  logic [OFF_W-1:0]       hw_r, hw_nxt;
  logic [BYTES_W-1:0]     biu_r, biu_nxt;
  logic [BYTES_W-1:0]     bm_r, bm_nxt;
  logic [MAX_PAGES-1:0]   mapped_r, mapped_nxt;
  logic                   ov_r, ov_nxt;

  // Working registers of the current command
  logic [SIZE_W-1:0]      size_r, size_nxt;
  logic [OFF_W-1:0]       off_r, off_nxt;
  logic                   off_ok_r, off_ok_nxt;
  logic [ADDR_W-1:0]      addr_r, addr_nxt;
  status_t                status_r, status_nxt;
  action_t                act_r, act_nxt;
  logic                   u_found_r, u_found_nxt;
  logic [U_IDX_W-1:0]     u_idx_r, u_idx_nxt;
  logic                   b_found_r, b_found_nxt;
  logic [F_IDX_W-1:0]     b_idx_r, b_idx_nxt;
  logic [OFF_W-1:0]       b_start_r, b_start_nxt;
  logic [OFF_W-1:0]       b_len_r, b_len_nxt;
  logic                   nx_found_r, nx_found_nxt;
  logic [F_IDX_W-1:0]     nx_idx_r, nx_idx_nxt;
  logic [OFF_W-1:0]       nx_len_r, nx_len_nxt;
  logic                   fe_found_r, fe_found_nxt;
  logic [F_IDX_W-1:0]     fe_idx_r, fe_idx_nxt;
  logic [MAX_PAGES-1:0]   mask_r, mask_nxt;
  logic [PG_W-1:0]        pg_r, pg_nxt;
  logic [PG_W-1:0]        pg_hi_r, pg_hi_nxt;
  logic [COV_W-1:0]       cov_r [MAX_PAGES];
  logic [COV_W-1:0]       cov_nxt [MAX_PAGES];

  // Result stage
  status_t                o_status_r, o_status_nxt;
  logic [ADDR_W-1:0]      o_addr_r, o_addr_nxt;
  logic [PG_W-1:0]        o_page_r, o_page_nxt;
  action_t                o_act_r, o_act_nxt;
  logic [BYTES_W-1:0]     o_alloc_r, o_alloc_nxt;
  logic [BYTES_W-1:0]     o_map_r, o_map_nxt;
  logic                   o_last_r, o_last_nxt;

  logic                   scanning;
  logic [SCAN_W-1:0]      scan_lim;
  logic                   issue_en;
  logic                   scan_done;
  logic                   can_load;
  logic [POS_W-1:0]       ovl [MAX_PAGES];
  logic [MAX_PAGES-1:0]   qual;
  logic [SIZE_W-1:0]      req_ext;
  logic [SIZE_W-1:0]      req_rnd;
  logic [ADDR_W-1:0]      free_off;
  logic [SIZE_W+1:0]      hw_sum;
  logic [SIZE_W+1:0]      pool_bytes;
  logic [SIZE_W-1:0]      end_m1;
  logic [SIZE_W-1:0]      f_end;
  logic [SIZE_W-1:0]      blk_end;
  logic [MAX_PAGES-1:0]   pg_bit;
  logic [BYTES_W-1:0]     bm_unmap;

  // Scan sequencing: issue one read per cycle, compare in the cycle after
  always_comb begin
    scanning = (state_r == S_A_SCAN) || (state_r == S_F_USCAN) ||
               (state_r == S_F_FSCAN) || (state_r == S_E_SCAN);
    case (state_r)
      S_A_SCAN:  scan_lim = SCAN_W'(SCAN_N);
      S_F_USCAN: scan_lim = SCAN_W'(N_USED);
      default:   scan_lim = SCAN_W'(N_FREE);
    endcase
    issue_en  = scanning && (scan_idx_r < scan_lim);
    scan_done = scanning && !issue_en && !cmp_vld_r;
    f_rd_en   = issue_en && (state_r != S_F_USCAN) && (scan_idx_r < SCAN_W'(N_FREE));
    u_rd_en   = issue_en && ((state_r == S_A_SCAN) || (state_r == S_F_USCAN)) &&
                (scan_idx_r < SCAN_W'(N_USED));
    f_rd_idx  = scan_idx_r[F_IDX_W-1:0];
    u_rd_idx  = scan_idx_r[U_IDX_W-1:0];
  end

  // Page coverage of the free entry being compared, one unit per page
  always_comb begin
    logic [POS_W-1:0] lo, hi, s, e, sm, em;
    for (int p = 0; p < MAX_PAGES; p++) begin
      lo = POS_W'(p) << PAGE_LOG2;
      hi = lo + POS_W'(PAGE_BYTES);
      s  = POS_W'(f_rd.start);
      e  = s + POS_W'(f_rd.len);
      sm = (s > lo) ? s : lo;
      em = (e < hi) ? e : hi;
      ovl[p]  = (em > sm) ? (em - sm) : '0;
      qual[p] = (p < int'(pool_np)) && mapped_r[p] &&
                (cov_r[p] == COV_W'(PAGE_BYTES));
    end
  end

  // Datapath terms
  always_comb begin
    req_ext    = (in_ch.request_size == '0) ? SIZE_W'(1) : SIZE_W'(in_ch.request_size);
    req_rnd    = (req_ext + SIZE_W'(ALIGN_BYTES - 1)) & ~SIZE_W'(ALIGN_BYTES - 1);
    free_off   = in_ch.block_address - base_address;
    hw_sum     = (SIZE_W+2)'(hw_r) + (SIZE_W+2)'(size_r);
    pool_bytes = (SIZE_W+2)'(pool_np) << PAGE_LOG2;
    end_m1     = SIZE_W'(off_r) + size_r - SIZE_W'(1);
    f_end      = SIZE_W'(f_rd.start) + SIZE_W'(f_rd.len);
    blk_end    = SIZE_W'(off_r) + size_r;
    pg_bit     = MAX_PAGES'(1) << pg_r;
    bm_unmap   = bm_r - BYTES_W'(PAGE_BYTES);
    can_load   = !ov_r || out_ch.ready;
  end

  // Next state and outputs
  always_comb begin
    state_nxt    = state_r;
    // the index restarts at zero whenever a scan completes
    scan_idx_nxt = (scanning && !scan_done) ?
                   (issue_en ? scan_idx_r + 1'b1 : scan_idx_r) : '0;
    cmp_vld_nxt  = issue_en;
    hw_nxt       = hw_r;
    biu_nxt      = biu_r;
    bm_nxt       = bm_r;
    mapped_nxt   = mapped_r;
    size_nxt     = size_r;
    off_nxt      = off_r;
    off_ok_nxt   = off_ok_r;
    addr_nxt     = addr_r;
    status_nxt   = status_r;
    act_nxt      = act_r;
    u_found_nxt  = u_found_r;
    u_idx_nxt    = u_idx_r;
    b_found_nxt  = b_found_r;
    b_idx_nxt    = b_idx_r;
    b_start_nxt  = b_start_r;
    b_len_nxt    = b_len_r;
    nx_found_nxt = nx_found_r;
    nx_idx_nxt   = nx_idx_r;
    nx_len_nxt   = nx_len_r;
    fe_found_nxt = fe_found_r;
    fe_idx_nxt   = fe_idx_r;
    mask_nxt     = mask_r;
    pg_nxt       = pg_r;
    pg_hi_nxt    = pg_hi_r;
    cov_nxt      = cov_r;
    o_status_nxt = o_status_r;
    o_addr_nxt   = o_addr_r;
    o_page_nxt   = o_page_r;
    o_act_nxt    = o_act_r;
    o_alloc_nxt  = o_alloc_r;
    o_map_nxt    = o_map_r;
    o_last_nxt   = o_last_r;
    ov_nxt       = out_ch.ready ? 1'b0 : ov_r;
    f_wr         = '0;
    f_wr_idx     = '0;
    u_wr         = '0;
    u_wr_idx     = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          status_nxt   = ST_OK;
          addr_nxt     = '0;
          u_found_nxt  = 1'b0;
          b_found_nxt  = 1'b0;
          nx_found_nxt = 1'b0;
          fe_found_nxt = 1'b0;
          case (cmd_t'(in_ch.command))
            CMD_ALLOC: begin
              size_nxt  = req_rnd;
              state_nxt = S_A_SCAN;
            end
            CMD_FREE: begin
              off_nxt    = free_off[OFF_W-1:0];
              off_ok_nxt = (free_off[ADDR_W-1:OFF_W] == '0);
              state_nxt  = S_F_USCAN;
            end
            CMD_EMPTY: begin
              for (int p = 0; p < MAX_PAGES; p++) cov_nxt[p] = '0;
              state_nxt = S_E_SCAN;
            end
            default: state_nxt = S_RESP;
          endcase
        end
      end

      // Allocate: first empty used entry and best-fit free entry
      S_A_SCAN: begin
        if (cmp_vld_r) begin
          if (u_rd.en && !u_rd.valid && !u_found_r) begin
            u_found_nxt = 1'b1;
            u_idx_nxt   = cmp_idx_r[U_IDX_W-1:0];
          end
          if (f_rd.valid && (SIZE_W'(f_rd.len) >= size_r) &&
              (!b_found_r || (f_rd.len < b_len_r) ||
               ((f_rd.len == b_len_r) && (f_rd.start < b_start_r)))) begin
            b_found_nxt = 1'b1;
            b_idx_nxt   = cmp_idx_r[F_IDX_W-1:0];
            b_start_nxt = f_rd.start;
            b_len_nxt   = f_rd.len;
          end
        end
        if (scan_done) begin
          if (!u_found_r) begin
            status_nxt = ST_FULL;
            state_nxt  = S_RESP;
          end else if (b_found_r) begin
            off_nxt   = b_start_r;
            state_nxt = S_A_WR_FREE;
          end else if (hw_sum > pool_bytes) begin
            status_nxt = ST_EXHAUSTED;
            state_nxt  = S_RESP;
          end else begin
            off_nxt   = hw_r;
            hw_nxt    = hw_sum[OFF_W-1:0];
            state_nxt = S_A_WR_USED;
          end
        end
      end

      // Split the chosen free block, or retire it on an exact fit
      S_A_WR_FREE: begin
        f_wr.en  = 1'b1;
        f_wr_idx = b_idx_r;
        if (SIZE_W'(b_len_r) > size_r) begin
          f_wr.valid = 1'b1;
          f_wr.start = b_start_r + size_r[OFF_W-1:0];
          f_wr.len   = b_len_r - size_r[OFF_W-1:0];
        end else begin
          f_wr.valid = 1'b0;
          f_wr.start = b_start_r;
          f_wr.len   = b_len_r;
        end
        state_nxt = S_A_WR_USED;
      end

      // Record the allocation and set up the page walk
      S_A_WR_USED: begin
        u_wr.en    = 1'b1;
        u_wr.valid = 1'b1;
        u_wr.start = off_r;
        u_wr.len   = size_r[OFF_W-1:0];
        u_wr_idx   = u_idx_r;
        biu_nxt    = biu_r + size_r[BYTES_W-1:0];
        addr_nxt   = base_address + ADDR_W'(off_r);
        pg_nxt     = off_r[PAGE_LOG2 +: PG_W];
        pg_hi_nxt  = end_m1[PAGE_LOG2 +: PG_W];
        mask_nxt   = '0;
        state_nxt  = S_A_MAP;
      end

      // Map every touched page that is not mapped yet
      S_A_MAP: begin
        if (!mapped_r[pg_r]) begin
          mapped_nxt[pg_r] = 1'b1;
          bm_nxt           = bm_r + BYTES_W'(PAGE_BYTES);
          mask_nxt[pg_r]   = 1'b1;
        end
        if (pg_r == pg_hi_r) begin
          pg_nxt  = '0;
          act_nxt = ACT_MAP;
          state_nxt = (mask_nxt == '0) ? S_RESP : S_EMIT;
        end else begin
          pg_nxt = pg_r + 1'b1;
        end
      end

      // Free: look up the live block by offset
      S_F_USCAN: begin
        if (cmp_vld_r && u_rd.valid && off_ok_r && (u_rd.start == off_r) && !u_found_r) begin
          u_found_nxt = 1'b1;
          u_idx_nxt   = cmp_idx_r[U_IDX_W-1:0];
          size_nxt    = SIZE_W'(u_rd.len);
        end
        if (scan_done) begin
          if (!u_found_r) begin
            status_nxt = ST_UNKNOWN;
            state_nxt  = S_RESP;
          end else begin
            state_nxt = S_F_FSCAN;
          end
        end
      end

      // Free: neighbours that end at its start / begin at its end, first empty slot
      S_F_FSCAN: begin
        if (cmp_vld_r) begin
          if (f_rd.en && !f_rd.valid && !fe_found_r) begin
            fe_found_nxt = 1'b1;
            fe_idx_nxt   = cmp_idx_r[F_IDX_W-1:0];
          end
          if (f_rd.valid && !b_found_r && (f_end == SIZE_W'(off_r))) begin
            b_found_nxt = 1'b1;
            b_idx_nxt   = cmp_idx_r[F_IDX_W-1:0];
            b_start_nxt = f_rd.start;
            b_len_nxt   = f_rd.len;
          end
          if (f_rd.valid && !nx_found_r && (SIZE_W'(f_rd.start) == blk_end)) begin
            nx_found_nxt = 1'b1;
            nx_idx_nxt   = cmp_idx_r[F_IDX_W-1:0];
            nx_len_nxt   = f_rd.len;
          end
        end
        if (scan_done) begin
          if (!b_found_r && !nx_found_r && !fe_found_r) begin
            status_nxt = ST_FULL;
            state_nxt  = S_RESP;
          end else begin
            state_nxt = S_F_WR1;
          end
        end
      end

      // Free: retire the used entry and merge into the free table
      S_F_WR1: begin
        u_wr.en    = 1'b1;
        u_wr.valid = 1'b0;
        u_wr_idx   = u_idx_r;
        biu_nxt    = biu_r - size_r[BYTES_W-1:0];
        f_wr.en    = 1'b1;
        f_wr.valid = 1'b1;
        if (b_found_r) begin
          f_wr_idx   = b_idx_r;
          f_wr.start = b_start_r;
          f_wr.len   = b_len_r + size_r[OFF_W-1:0] + (nx_found_r ? nx_len_r : '0);
        end else if (nx_found_r) begin
          f_wr_idx   = nx_idx_r;
          f_wr.start = off_r;
          f_wr.len   = nx_len_r + size_r[OFF_W-1:0];
        end else begin
          f_wr_idx   = fe_idx_r;
          f_wr.start = off_r;
          f_wr.len   = size_r[OFF_W-1:0];
        end
        state_nxt = (b_found_r && nx_found_r) ? S_F_WR2 : S_RESP;
      end

      // Free: the following neighbour was absorbed
      S_F_WR2: begin
        f_wr.en    = 1'b1;
        f_wr.valid = 1'b0;
        f_wr_idx   = nx_idx_r;
        state_nxt  = S_RESP;
      end

      // Empty cache: accumulate free coverage of every page
      S_E_SCAN: begin
        if (cmp_vld_r && f_rd.valid) begin
          for (int p = 0; p < MAX_PAGES; p++) begin
            cov_nxt[p] = cov_r[p] + COV_W'(ovl[p]);
          end
        end
        if (scan_done) state_nxt = S_E_QUAL;
      end

      S_E_QUAL: begin
        mask_nxt  = qual;
        pg_nxt    = '0;
        act_nxt   = ACT_UNMAP;
        state_nxt = (qual == '0) ? S_RESP : S_EMIT;
      end

      // One result per marked page, in page order
      S_EMIT: begin
        if (mask_r[pg_r]) begin
          if (can_load) begin
            ov_nxt       = 1'b1;
            o_status_nxt = ST_OK;
            o_addr_nxt   = addr_r;
            o_page_nxt   = pg_r;
            o_act_nxt    = act_r;
            o_alloc_nxt  = biu_r;
            o_map_nxt    = bm_r;
            o_last_nxt   = ((mask_r & ~pg_bit) == '0);
            mask_nxt     = mask_r & ~pg_bit;
            if (act_r == ACT_UNMAP) begin
              mapped_nxt[pg_r] = 1'b0;
              bm_nxt           = bm_unmap;
              o_map_nxt        = bm_unmap;
            end
            if ((mask_r & ~pg_bit) == '0) state_nxt = S_IDLE;
            else pg_nxt = pg_r + 1'b1;
          end
        end else begin
          pg_nxt = pg_r + 1'b1;
        end
      end

      // Single result with no page action
      S_RESP: begin
        if (can_load) begin
          ov_nxt       = 1'b1;
          o_status_nxt = status_r;
          o_addr_nxt   = addr_r;
          o_page_nxt   = '0;
          o_act_nxt    = ACT_NONE;
          o_alloc_nxt  = biu_r;
          o_map_nxt    = bm_r;
          o_last_nxt   = 1'b1;
          state_nxt    = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      scan_idx_r <= '0;
      cmp_vld_r  <= 1'b0;
      hw_r       <= '0;
      biu_r      <= '0;
      bm_r       <= '0;
      mapped_r   <= '0;
      ov_r       <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      scan_idx_r <= scan_idx_nxt;
      cmp_vld_r  <= cmp_vld_nxt;
      hw_r       <= hw_nxt;
      biu_r      <= biu_nxt;
      bm_r       <= bm_nxt;
      mapped_r   <= mapped_nxt;
      ov_r       <= ov_nxt;
    end
  end

  // Working and result registers
  always_ff @(posedge clk) begin
    cmp_idx_r  <= scan_idx_r;
    size_r     <= size_nxt;
    off_r      <= off_nxt;
    off_ok_r   <= off_ok_nxt;
    addr_r     <= addr_nxt;
    status_r   <= status_nxt;
    act_r      <= act_nxt;
    u_found_r  <= u_found_nxt;
    u_idx_r    <= u_idx_nxt;
    b_found_r  <= b_found_nxt;
    b_idx_r    <= b_idx_nxt;
    b_start_r  <= b_start_nxt;
    b_len_r    <= b_len_nxt;
    nx_found_r <= nx_found_nxt;
    nx_idx_r   <= nx_idx_nxt;
    nx_len_r   <= nx_len_nxt;
    fe_found_r <= fe_found_nxt;
    fe_idx_r   <= fe_idx_nxt;
    mask_r     <= mask_nxt;
    pg_r       <= pg_nxt;
    pg_hi_r    <= pg_hi_nxt;
    cov_r      <= cov_nxt;
    o_status_r <= o_status_nxt;
    o_addr_r   <= o_addr_nxt;
    o_page_r   <= o_page_nxt;
    o_act_r    <= o_act_nxt;
    o_alloc_r  <= o_alloc_nxt;
    o_map_r    <= o_map_nxt;
    o_last_r   <= o_last_nxt;
  end

  assign in_ch.ready            = (state_r == S_IDLE);
  assign out_ch.valid           = ov_r;
  assign out_ch.status          = o_status_r;
  assign out_ch.result_address  = o_addr_r;
  assign out_ch.page_index      = o_page_r;
  assign out_ch.page_action     = o_act_r;
  assign out_ch.allocated_bytes = o_alloc_r;
  assign out_ch.mapped_bytes    = o_map_r;
  assign out_ch.last            = o_last_r;

endmodule

### sv/bfpa_checker.sv
// Port-level checks of the allocator's command and result streams,
// bound to the top level. Depends on bfpa_pkg and best_fit_pool_allocator.
module bfpa_checker import bfpa_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [1:0]        status,
  input logic [ADDR_W-1:0] result_address,
  input logic [PG_W-1:0]   page_index,
  input logic [1:0]        page_action,
  input logic              last
);

  // A stalled result holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(result_address) &&
                                $stable(status) && $stable(last))
    else $error("result changed while stalled");

  // One command at a time: no acceptance right after an acceptance
  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("command accepted while busy");

  // Errors come as a single result without page action
  a_err_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (status != ST_OK) |-> last && (page_action == ACT_NONE))
    else $error("error result not single");

  // No page action means page index zero
  a_page_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (page_action == ACT_NONE) |-> (page_index == '0))
    else $error("page index without action");

  // Page actions only on successful commands
  a_act_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (page_action != ACT_NONE) |-> (status == ST_OK))
    else $error("page action with error status");

endmodule

bind best_fit_pool_allocator bfpa_checker u_bfpa_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .status         (out_ch.status),
  .result_address (out_ch.result_address),
  .page_index     (out_ch.page_index),
  .page_action    (out_ch.page_action),
  .last           (out_ch.last)
);
